### sv/bpar_pkg.sv
package bpar_pkg;

    // Unlock sequence and session control bytes.
    localparam logic [7:0] UNLOCK_A      = 8'h72;
    localparam logic [7:0] UNLOCK_B      = 8'h34;
    localparam logic [7:0] UNLOCK_C      = 8'h61;
    localparam logic [7:0] UNLOCK_REPLY  = 8'hE7;
    localparam logic [7:0] CMD_CLOSE     = 8'hF3;
    localparam logic [7:0] CMD_IGNORED   = 8'hE3;

    // Block transfer commands and register ids.
    localparam logic [7:0] CMD_BLOCK_OUT = 8'h43;
    localparam logic [7:0] CMD_BLOCK_IN  = 8'h53;
    localparam logic [7:0] CMD_BLOCK_END = 8'h51;
    localparam logic [7:0] ID_DATA_READ  = 8'h41;
    localparam logic [7:0] ID_DATA_WRITE = 8'h12;
    localparam logic [7:0] CMD_STATUS    = 8'h21;
    localparam logic [7:0] CMD_RESET     = 8'h13;

    localparam logic [1:0] UNLOCK_DONE   = 2'd3;

    typedef enum logic [1:0] {
        PH_ID     = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2,
        PH_STATUS = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BM_NONE   = 2'd0,
        BM_OUT    = 2'd1,
        BM_IN     = 2'd2,
        BM_IN_END = 2'd3
    } t_block_mode;

    typedef struct packed {
        logic        session;
        logic [1:0]  unlock;
        logic [7:0]  cur_reg;
        t_phase      phase;
        logic [7:0]  low_latch;
        logic [15:0] fetched;
        t_block_mode block;
        logic [15:0] checksum;
        logic        reset_hold;
    } t_state;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        drive_write;
        logic        drive_read;
        logic [7:0]  drive_reg;
        logic [15:0] drive_value;
        logic        reset_line;
        logic        session_open;
    } t_result;

endpackage

### sv/bpar_req_if.sv
interface bpar_req_if;
    logic        valid;
    logic        ready;
    logic        access_is_read;
    logic [7:0]  port_byte;
    logic [15:0] drive_word;
    logic        drive_done;

    modport source (
        output valid, access_is_read, port_byte, drive_word, drive_done,
        input  ready
    );
    modport sink (
        input  valid, access_is_read, port_byte, drive_word, drive_done,
        output ready
    );
endinterface

### sv/bpar_rsp_if.sv
interface bpar_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic        drive_write;
    logic        drive_read;
    logic [7:0]  drive_reg;
    logic [15:0] drive_value;
    logic        reset_line;
    logic        session_open;

    modport source (
        output valid, read_byte, drive_write, drive_read, drive_reg, drive_value,
               reset_line, session_open,
        input  ready
    );
    modport sink (
        input  valid, read_byte, drive_write, drive_read, drive_reg, drive_value,
               reset_line, session_open,
        output ready
    );
endinterface

### sv/bpar_step.sv
module bpar_step #(
    parameter int BLOCK_WORDS = 256,
    localparam int CNT_W = $clog2(BLOCK_WORDS)
) (
    input  bpar_pkg::t_state  i_state,
    input  logic [CNT_W-1:0]  i_count,
    input  logic              i_access_is_read,
    input  logic [7:0]        i_port_byte,
    input  logic [15:0]       i_drive_word,
    input  logic              i_drive_done,
    output bpar_pkg::t_state  o_state,
    output logic [CNT_W-1:0]  o_count,
    output bpar_pkg::t_result o_result
);
    import bpar_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_WORDS - 1);

    t_state      s;
    t_result     r;
    logic [CNT_W-1:0] cnt;
    logic        wkind;
    logic        add_en;
    logic [15:0] add_word;
    logic [7:0]  unlock_byte;
    logic        unlock_hit;

    always_comb begin
        case (i_state.unlock)
            2'd0:    unlock_byte = UNLOCK_A;
            2'd1:    unlock_byte = UNLOCK_B;
            2'd2:    unlock_byte = UNLOCK_C;
            default: unlock_byte = UNLOCK_A;
        endcase
        unlock_hit = (i_state.unlock != UNLOCK_DONE) && (i_port_byte == unlock_byte);
    end

    always_comb begin
        s        = i_state;
        cnt      = i_count;
        r        = '0;
        add_en   = 1'b0;
        add_word = '0;
        wkind    = i_state.cur_reg[1];

        if (!i_state.session) begin
            if (i_access_is_read) begin
                if (i_state.unlock == UNLOCK_DONE) begin
                    r.read_byte = UNLOCK_REPLY;
                    s.session   = 1'b1;
                    s.phase     = PH_ID;
                    s.block     = BM_NONE;
                end
                s.unlock = 2'd0;
            end else if (unlock_hit) begin
                s.unlock = i_state.unlock + 2'd1;
            end else begin
                s.unlock = (i_port_byte == UNLOCK_A) ? 2'd1 : 2'd0;
            end
        end else if (!i_access_is_read) begin
            if (i_state.phase == PH_LOW && wkind) begin
                s.low_latch = i_port_byte;
                s.phase     = PH_HIGH;
            end else if (i_state.phase == PH_HIGH && wkind) begin
                if (i_state.cur_reg == CMD_RESET) begin
                    s.reset_hold = i_port_byte[0];
                end else begin
                    r.drive_write = 1'b1;
                    r.drive_reg   = i_state.cur_reg;
                    r.drive_value = {i_port_byte, i_state.low_latch};
                    if (i_state.block == BM_OUT && i_state.cur_reg == ID_DATA_WRITE) begin
                        add_en   = 1'b1;
                        add_word = {i_port_byte, i_state.low_latch};
                    end
                end
                s.phase = PH_ID;
            end else begin
                // Any other write is a command or a new register id.
                if (i_port_byte == CMD_CLOSE) begin
                    s.session = 1'b0;
                    s.unlock  = 2'd0;
                    s.phase   = PH_ID;
                    s.block   = BM_NONE;
                end else if (i_port_byte == CMD_IGNORED) begin
                    s.phase = PH_ID;
                end else if (i_port_byte == CMD_RESET) begin
                    s.cur_reg = i_port_byte;
                    s.phase   = PH_HIGH;
                end else if (i_port_byte == CMD_STATUS) begin
                    s.cur_reg = i_port_byte;
                    s.phase   = PH_STATUS;
                end else if (i_port_byte == CMD_BLOCK_OUT || i_port_byte == CMD_BLOCK_IN) begin
                    s.block    = (i_port_byte == CMD_BLOCK_OUT) ? BM_OUT : BM_IN;
                    s.checksum = '0;
                    cnt        = '0;
                    s.phase    = PH_ID;
                end else if (i_port_byte == CMD_BLOCK_END) begin
                    if (i_state.block == BM_IN) begin
                        s.block = BM_IN_END;
                    end
                    s.phase = PH_ID;
                end else begin
                    s.cur_reg = i_port_byte;
                    s.phase   = PH_LOW;
                end
            end
        end else begin
            if (i_state.phase == PH_LOW && !wkind) begin
                if (i_state.cur_reg == ID_DATA_READ &&
                    (i_state.block == BM_OUT || i_state.block == BM_IN_END)) begin
                    s.fetched = i_state.checksum;
                    s.block   = BM_NONE;
                end else begin
                    r.drive_read = 1'b1;
                    r.drive_reg  = i_state.cur_reg;
                    s.fetched    = i_drive_word;
                end
                r.read_byte = s.fetched[7:0];
                s.phase     = PH_HIGH;
            end else if (i_state.phase == PH_HIGH && !wkind) begin
                r.read_byte = i_state.fetched[15:8];
                if (i_state.block == BM_IN && i_state.cur_reg == ID_DATA_READ) begin
                    add_en   = 1'b1;
                    add_word = i_state.fetched;
                end
                s.phase = PH_ID;
            end else if (i_state.phase == PH_STATUS) begin
                r.read_byte = {7'd0, i_drive_done};
                s.phase     = PH_ID;
            end else if (i_state.phase == PH_ID && i_state.block == BM_IN) begin
                // A bare read during block in streams the next drive word.
                r.drive_read = 1'b1;
                r.drive_reg  = ID_DATA_READ;
                s.cur_reg    = ID_DATA_READ;
                s.fetched    = i_drive_word;
                r.read_byte  = i_drive_word[7:0];
                s.phase      = PH_HIGH;
            end
        end

        if (add_en) begin
            s.checksum = i_state.checksum ^ (add_word + 16'(i_count));
            cnt        = (i_count == CNT_LAST) ? '0 : i_count + 1'b1;
        end

        r.reset_line   = s.reset_hold;
        r.session_open = s.session;
    end

    assign o_state  = s;
    assign o_count  = cnt;
    assign o_result = r;

endmodule

### sv/byte_port_ata_register_bridge.sv
// Byte-wide host port to ATA taskfile bridge.
// Each host port access enters on i_req as one transaction: a write carries
// port_byte, a read ignores it. drive_word and drive_done show what the drive
// presents for that access. Exactly one result leaves on o_rsp per request:
// the byte returned to the host, the drive write or fetch strobe with its
// register id and word, and the current reset line and session flag.
// A request accepted at one edge has its result valid right after that edge.
// Throughput is one request per cycle while the receiver takes each result;
// it is set by the single session state register, updated in the accept cycle.
// The result register frees itself when o_rsp is taken, so a new request is
// accepted in the same cycle that the previous result leaves. When the
// receiver stalls, the result holds and i_req.ready drops until it is taken.
// Synchronous reset closes the session, clears the unlock progress, the
// block checksum and word index, releases the drive reset line and empties
// the result register.
module byte_port_ata_register_bridge #(
    parameter int BLOCK_WORDS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpar_req_if.sink   i_req,
    bpar_rsp_if.source o_rsp
);
    import bpar_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_WORDS);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_result          r_result;
    t_result          n_result;
    logic             r_valid;
    logic             accept;

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    bpar_step #(
        .BLOCK_WORDS(BLOCK_WORDS)
    ) u_step (
        .i_state         (r_state),
        .i_count         (r_count),
        .i_access_is_read(i_req.access_is_read),
        .i_port_byte     (i_req.port_byte),
        .i_drive_word    (i_req.drive_word),
        .i_drive_done    (i_req.drive_done),
        .o_state         (n_state),
        .o_count         (n_count),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.read_byte    = r_result.read_byte;
    assign o_rsp.drive_write  = r_result.drive_write;
    assign o_rsp.drive_read   = r_result.drive_read;
    assign o_rsp.drive_reg    = r_result.drive_reg;
    assign o_rsp.drive_value  = r_result.drive_value;
    assign o_rsp.reset_line   = r_result.reset_line;
    assign o_rsp.session_open = r_result.session_open;

endmodule

### sv/bpar_checker.sv
module bpar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_read_byte,
    input logic        i_drive_write,
    input logic        i_drive_read,
    input logic [7:0]  i_drive_reg,
    input logic [15:0] i_drive_value
);

    // The result register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_read_byte) && $stable(i_drive_reg) && $stable(i_drive_value))
        else $error("stalled result changed");

    // One access never both writes and fetches a drive word.
    a_one_drive_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_drive_write && i_drive_read))
        else $error("drive write and fetch in one transaction");

    // Forwarded writes always use a write-kind register id.
    a_write_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_write |-> i_drive_reg[1])
        else $error("drive write with a read-kind register id");

    // Fetches always use a read-kind register id.
    a_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_drive_read |-> !i_drive_reg[1])
        else $error("drive fetch with a write-kind register id");

endmodule

bind byte_port_ata_register_bridge bpar_checker u_bpar_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_byte  (o_rsp.read_byte),
    .i_drive_write(o_rsp.drive_write),
    .i_drive_read (o_rsp.drive_read),
    .i_drive_reg  (o_rsp.drive_reg),
    .i_drive_value(o_rsp.drive_value)
);

### tb/tb_byte_port_ata_register_bridge.sv
`timescale 1ns / 1ps

module tb_byte_port_ata_register_bridge;
    import bpar_pkg::*;

    localparam int BLOCK_WORDS      = 256;
    localparam int RANDOM_ITEMS     = 1250;
    localparam int LONG_BLOCK_WORDS = BLOCK_WORDS + 1;
    localparam int QUIET_LIMIT      = 2000;
    localparam int HOLD_AT          = 1200;
    localparam int HOLD_CYCLES      = 300;
    localparam int CALM_FROM        = 300;
    localparam int CALM_TO          = 700;
    localparam int REPORT_LIMIT     = 10;

    localparam logic [7:0] SPECIAL_BYTES [10] = '{
        CMD_CLOSE, CMD_IGNORED, CMD_RESET, CMD_STATUS, CMD_BLOCK_OUT,
        CMD_BLOCK_IN, CMD_BLOCK_END, ID_DATA_READ, ID_DATA_WRITE, UNLOCK_A
    };

    typedef struct {
        bit          rd;
        logic [7:0]  data;
        logic [15:0] word;
        bit          done;
    } t_access;

    // Tracks the bridge state and holds the results it must produce, oldest first.
    class bridge_result_tracker;
        bit          session;
        logic [1:0]  unlock;
        logic [7:0]  cur_reg;
        t_phase      phase;
        logic [7:0]  low_latch;
        logic [15:0] fetched;
        t_block_mode block;
        logic [15:0] checksum;
        logic [7:0]  word_idx;
        bit          reset_hold;
        logic [7:0]  unlock_seq [3] = '{UNLOCK_A, UNLOCK_B, UNLOCK_C};

        t_result     awaited_results[$];
        int          errors;
        int          checked;
        int          sessions_opened;
        int          drive_writes;
        int          drive_fetches;
        int          checksum_reads;
        int          index_wraps;

        function new();
            session    = 1'b0;
            unlock     = 2'd0;
            cur_reg    = 8'h00;
            phase      = PH_ID;
            low_latch  = 8'h00;
            fetched    = 16'h0000;
            block      = BM_NONE;
            checksum   = 16'h0000;
            word_idx   = 8'h00;
            reset_hold = 1'b0;
        endfunction

        function void fold_into_checksum(logic [15:0] w);
            checksum = checksum ^ (w + {8'h00, word_idx});
            if (word_idx == 8'(BLOCK_WORDS - 1)) begin
                word_idx = 8'h00;
                index_wraps++;
            end else begin
                word_idx = word_idx + 8'd1;
            end
        endfunction

        function void take_command(logic [7:0] b);
            if (b == CMD_CLOSE) begin
                session = 1'b0;
                unlock  = 2'd0;
                phase   = PH_ID;
                block   = BM_NONE;
            end else if (b == CMD_IGNORED) begin
                phase = PH_ID;
            end else if (b == CMD_RESET) begin
                cur_reg = b;
                phase   = PH_HIGH;
            end else if (b == CMD_STATUS) begin
                cur_reg = b;
                phase   = PH_STATUS;
            end else if (b == CMD_BLOCK_OUT || b == CMD_BLOCK_IN) begin
                block    = (b == CMD_BLOCK_OUT) ? BM_OUT : BM_IN;
                checksum = 16'h0000;
                word_idx = 8'h00;
                phase    = PH_ID;
            end else if (b == CMD_BLOCK_END) begin
                if (block == BM_IN) begin
                    block = BM_IN_END;
                end
                phase = PH_ID;
            end else begin
                cur_reg = b;
                phase   = PH_LOW;
            end
        endfunction

        function void note_access(t_access a);
            t_result r;
            bit      wkind;
            r     = '0;
            wkind = cur_reg[1];
            if (!session) begin
                if (a.rd) begin
                    if (unlock == UNLOCK_DONE) begin
                        r.read_byte = UNLOCK_REPLY;
                        session     = 1'b1;
                        phase       = PH_ID;
                        block       = BM_NONE;
                        sessions_opened++;
                    end
                    unlock = 2'd0;
                end else if (unlock != UNLOCK_DONE && a.data == unlock_seq[unlock]) begin
                    unlock = unlock + 2'd1;
                end else begin
                    // A wrong byte restarts the unlock, but may itself be its first byte.
                    unlock = (a.data == UNLOCK_A) ? 2'd1 : 2'd0;
                end
            end else if (!a.rd) begin
                if (phase == PH_LOW && wkind) begin
                    low_latch = a.data;
                    phase     = PH_HIGH;
                end else if (phase == PH_HIGH && wkind) begin
                    if (cur_reg == CMD_RESET) begin
                        reset_hold = a.data[0];
                    end else begin
                        r.drive_write = 1'b1;
                        r.drive_reg   = cur_reg;
                        r.drive_value = {a.data, low_latch};
                        if (block == BM_OUT && cur_reg == ID_DATA_WRITE) begin
                            fold_into_checksum(r.drive_value);
                        end
                    end
                    phase = PH_ID;
                end else begin
                    take_command(a.data);
                end
            end else begin
                if (phase == PH_LOW && !wkind) begin
                    if (cur_reg == ID_DATA_READ && (block == BM_OUT || block == BM_IN_END)) begin
                        fetched = checksum;
                        block   = BM_NONE;
                        checksum_reads++;
                    end else begin
                        r.drive_read = 1'b1;
                        r.drive_reg  = cur_reg;
                        fetched      = a.word;
                    end
                    r.read_byte = fetched[7:0];
                    phase       = PH_HIGH;
                end else if (phase == PH_HIGH && !wkind) begin
                    r.read_byte = fetched[15:8];
                    if (block == BM_IN && cur_reg == ID_DATA_READ) begin
                        fold_into_checksum(fetched);
                    end
                    phase = PH_ID;
                end else if (phase == PH_STATUS) begin
                    r.read_byte = {7'd0, a.done};
                    phase       = PH_ID;
                end else if (phase == PH_ID && block == BM_IN) begin
                    // A bare read during a block in fetches the next data word.
                    r.drive_read = 1'b1;
                    r.drive_reg  = ID_DATA_READ;
                    cur_reg      = ID_DATA_READ;
                    fetched      = a.word;
                    r.read_byte  = a.word[7:0];
                    phase        = PH_HIGH;
                end
            end
            r.reset_line   = reset_hold;
            r.session_open = session;
            if (r.drive_write) drive_writes++;
            if (r.drive_read) drive_fetches++;
            awaited_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("Unexpected result with nothing awaited: %p", got);
                end
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $write("Result %0d mismatch: expected byte=%02h wr=%0d fetch=%0d",
                           checked, want.read_byte, want.drive_write, want.drive_read);
                    $display(" reg=%02h val=%04h rst=%0d sess=%0d",
                             want.drive_reg, want.drive_value, want.reset_line,
                             want.session_open);
                    $write("    actual byte=%02h wr=%0d fetch=%0d",
                           got.read_byte, got.drive_write, got.drive_read);
                    $display(" reg=%02h val=%04h rst=%0d sess=%0d",
                             got.drive_reg, got.drive_value, got.reset_line,
                             got.session_open);
                end
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cyc   = 0;

    bpar_req_if req_if();
    bpar_rsp_if rsp_if();

    byte_port_ata_register_bridge #(
        .BLOCK_WORDS(BLOCK_WORDS)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    bridge_result_tracker tracker = new();
    t_access              port_ops[$];

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cyc <= cyc + 1;
    end

    function automatic bit take_break();
        return (cyc < CALM_FROM || cyc >= CALM_TO) && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic void push_access(bit rd, logic [7:0] b, logic [15:0] w, bit d);
        t_access a;
        a.rd   = rd;
        a.data = b;
        a.word = w;
        a.done = d;
        port_ops.push_back(a);
    endfunction

    function automatic void push_write(logic [7:0] b);
        push_access(1'b0, b, 16'($urandom), 1'($urandom));
    endfunction

    function automatic void push_read();
        push_access(1'b1, 8'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    function automatic void push_unlock();
        push_write(UNLOCK_A);
        push_write(UNLOCK_B);
        push_write(UNLOCK_C);
        push_read();
    endfunction

    function automatic logic [7:0] random_register_id(bit for_write);
        logic [7:0] id;
        do begin
            id    = 8'($urandom);
            id[1] = for_write;
        end while (id inside {CMD_CLOSE, CMD_IGNORED, CMD_RESET, CMD_STATUS,
                              CMD_BLOCK_OUT, CMD_BLOCK_IN, CMD_BLOCK_END});
        return id;
    endfunction

    // Both handshakes are observed here, before any register updates of the edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                tracker.note_access('{rd: req_if.access_is_read, data: req_if.port_byte,
                                      word: req_if.drive_word, done: req_if.drive_done});
            end
            if (rsp_if.valid && rsp_if.ready) begin
                tracker.check_result('{read_byte: rsp_if.read_byte,
                                       drive_write: rsp_if.drive_write,
                                       drive_read: rsp_if.drive_read,
                                       drive_reg: rsp_if.drive_reg,
                                       drive_value: rsp_if.drive_value,
                                       reset_line: rsp_if.reset_line,
                                       session_open: rsp_if.session_open});
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("byte_port_ata_register_bridge verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off that backs up the input.
    initial begin : result_sink
        int held;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (cyc == HOLD_AT) begin
                rsp_if.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(negedge clk);
                end
            end else begin
                rsp_if.ready <= !take_break();
            end
        end
    end

    task automatic send_port_ops();
        int idx;
        idx = 0;
        while (idx < port_ops.size()) begin
            @(negedge clk);
            if (take_break()) begin
                req_if.valid <= 1'b0;
            end else begin
                req_if.valid          <= 1'b1;
                req_if.access_is_read <= port_ops[idx].rd;
                req_if.port_byte      <= port_ops[idx].data;
                req_if.drive_word     <= port_ops[idx].word;
                req_if.drive_done     <= port_ops[idx].done;
                do @(posedge clk); while (!req_if.ready);
                idx++;
            end
        end
        @(negedge clk);
        req_if.valid <= 1'b0;
    endtask

    initial begin : main_flow
        int  directed_len;
        int  n;
        int  k;
        bit  need_unlock;
        bit  long_done;
        int  kind;

        req_if.valid          = 1'b0;
        req_if.access_is_read = 1'b0;
        req_if.port_byte      = 8'h00;
        req_if.drive_word     = 16'h0000;
        req_if.drive_done     = 1'b0;

        // Directed opening: closed reads, broken and restarted unlocks, extreme ids and
        // words, the ignored byte, status, the drive reset line and closing the session.
        push_read();
        push_write(UNLOCK_A);
        push_write(UNLOCK_B);
        push_read();
        push_write(UNLOCK_A);
        push_write(UNLOCK_A);
        push_write(UNLOCK_B);
        push_write(UNLOCK_C);
        push_read();
        push_write(8'hFF);
        push_write(8'hFF);
        push_write(8'hFF);
        push_write(8'h00);
        push_access(1'b1, 8'h00, 16'hFFFF, 1'b0);
        push_access(1'b1, 8'hFF, 16'h0000, 1'b1);
        push_write(CMD_IGNORED);
        push_write(CMD_STATUS);
        push_access(1'b1, 8'h00, 16'h0000, 1'b1);
        push_write(CMD_RESET);
        push_write(8'h01);
        push_write(CMD_RESET);
        push_write(8'hFE);
        push_write(CMD_CLOSE);
        push_read();
        directed_len = port_ops.size();

        need_unlock = 1'b1;
        long_done   = 1'b0;
        while (port_ops.size() - directed_len < RANDOM_ITEMS) begin
            kind = (!long_done && port_ops.size() - directed_len > 400) ? 12 :
                   $urandom_range(0, 11);
            if (need_unlock || kind == 12 || $urandom_range(0, 9) == 0) begin
                // Three closes reach the closed state from any phase of a transfer.
                push_write(CMD_CLOSE);
                push_write(CMD_CLOSE);
                push_write(CMD_CLOSE);
                push_unlock();
                need_unlock = 1'b0;
            end
            case (kind)
                0, 1: begin
                    push_write(random_register_id(1'b1));
                    if ($urandom_range(0, 5) == 0) push_read();
                    push_write(8'($urandom));
                    push_write(8'($urandom));
                end
                2, 3: begin
                    push_write(($urandom_range(0, 3) == 0) ? ID_DATA_READ :
                               random_register_id(1'b0));
                    push_read();
                    if ($urandom_range(0, 5) != 0) push_read();
                end
                4: begin
                    push_write(CMD_STATUS);
                    push_read();
                end
                5: begin
                    push_write(CMD_RESET);
                    push_write(8'($urandom));
                end
                6, 7: begin
                    push_write(CMD_BLOCK_OUT);
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0) begin
                            push_write(random_register_id(1'b1));
                            push_write(8'($urandom));
                            push_write(8'($urandom));
                        end
                        push_write(ID_DATA_WRITE);
                        push_write(8'($urandom));
                        push_write(8'($urandom));
                    end
                    push_write(ID_DATA_READ);
                    push_read();
                    push_read();
                end
                8, 9: begin
                    push_write(CMD_BLOCK_IN);
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 4) == 0) begin
                            if ($urandom_range(0, 1) == 0) begin
                                push_write(CMD_STATUS);
                                push_read();
                            end else begin
                                push_write(CMD_IGNORED);
                            end
                        end
                        push_read();
                        push_read();
                    end
                    // Now and then the checksum is asked for before the block is ended.
                    if ($urandom_range(0, 5) != 0) push_write(CMD_BLOCK_END);
                    push_write(ID_DATA_READ);
                    push_read();
                    push_read();
                end
                10: begin
                    push_write(CMD_CLOSE);
                    push_read();
                    case ($urandom_range(0, 2))
                        0: begin
                            push_write(UNLOCK_A);
                            push_write(UNLOCK_B);
                            push_read();
                        end
                        1: begin
                            push_write(UNLOCK_A);
                            push_write(UNLOCK_B);
                            push_write(UNLOCK_C);
                            push_write(UNLOCK_A);
                        end
                        default: begin
                            push_write(UNLOCK_A);
                            push_write(UNLOCK_C);
                        end
                    endcase
                    push_unlock();
                end
                11: begin
                    k = $urandom_range(1, 6);
                    repeat (k) begin
                        push_access(1'($urandom),
                                    ($urandom_range(0, 3) == 0) ?
                                        SPECIAL_BYTES[$urandom_range(0, 9)] : 8'($urandom),
                                    16'($urandom), 1'($urandom));
                    end
                    need_unlock = 1'b1;
                end
                default: begin
                    // One block in long enough to wrap the word index.
                    push_write(CMD_BLOCK_IN);
                    repeat (LONG_BLOCK_WORDS) begin
                        push_read();
                        push_read();
                    end
                    push_write(CMD_BLOCK_END);
                    push_write(ID_DATA_READ);
                    push_read();
                    push_read();
                    long_done = 1'b1;
                end
            endcase
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_port_ops();
        while (tracker.awaited_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.awaited_results.size() != 0) begin
            $display("%0d expected results never arrived", tracker.awaited_results.size());
        end
        $write("Run covered %0d port accesses and %0d checked results: ",
               port_ops.size(), tracker.checked);
        $display("%0d sessions opened, %0d drive writes, %0d drive fetches.",
                 tracker.sessions_opened, tracker.drive_writes, tracker.drive_fetches);
        $display("%0d block checksums read back, word index wrapped %0d time(s), %0d errors.",
                 tracker.checksum_reads, tracker.index_wraps, tracker.errors);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
            $display("byte_port_ata_register_bridge verification clean");
        end else begin
            $display("byte_port_ata_register_bridge verification failed");
        end
        $finish;
    end

endmodule
